FILE: src/rvz_pkg.sv
`default_nettype none

package rvz_pkg;

  localparam int CORDIC_STAGES_DEF = 20;
  localparam int GUARD             = 24;
  localparam int ANG_FRAC          = 60;

  // datapath widths: x/y carry GUARD fraction bits plus cordic growth, z is Q60 radians
  localparam int XW = 59;
  localparam int ZW = 63;

  localparam int DEG_Q16_360 = 360 * 65536;
  localparam int DEG_Q16_180 = 180 * 65536;
  localparam int DEG_Q16_90  = 90 * 65536;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [31:0]          zp;
  } rvz_cdc_t;

  // long division, used for elaboration-time constants only
  function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    int          b;
    rem = '0;
    q   = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/m) in Q60 by its power series
  function automatic logic signed [63:0] atan_recip(input logic [63:0] m);
    logic [63:0]        p;
    logic [63:0]        mm;
    logic [63:0]        t;
    logic [63:0]        k;
    logic signed [63:0] s;
    p  = cdiv(64'd1 << ANG_FRAC, m);
    mm = m * m;
    s  = '0;
    k  = '0;
    while (p != 64'd0) begin
      t = cdiv(p, 64'd2 * k + 64'd1);
      if (k[0]) begin
        s = s - signed'(t);
      end else begin
        s = s + signed'(t);
      end
      p = cdiv(p, mm);
      k = k + 64'd1;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] quarter_pi();
    return 64'sd4 * atan_recip(64'd5) - atan_recip(64'd239);
  endfunction

  function automatic logic [63:0] atan_q60(input int i);
    if (i == 0) begin
      return quarter_pi();
    end else begin
      return atan_recip(64'd1 << i);
    end
  endfunction

  function automatic logic [63:0] deg_to_rad();
    logic [63:0] pi_q;
    pi_q = 64'(quarter_pi()) * 64'd4;
    return cdiv(pi_q + 64'd90, 64'd180);
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) begin
      b = b >> 2;
    end
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q32 inverse cordic gain for n micro-rotations
  function automatic logic [31:0] kgain_q32(input int n);
    logic [63:0] g;
    logic [63:0] s;
    logic [63:0] r;
    int          i;
    g = 64'd1 << ANG_FRAC;
    for (i = 0; i < n; i++) begin
      g = g + (g >> (2 * i));
    end
    s = isqrt64(g);
    r = cdiv((64'd1 << 62) + (s >> 1), s);
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/rotate_vector_about_z_core.sv
`default_nettype none

// Rotates a Q15.16 vector (x, y, z) counterclockwise about the z axis by an angle in
// Q15.16 degrees; z passes through. The angle is reduced exactly modulo 360 and folded
// into [-90, 90] (negating x and y), converted to Q60 radians and fed to a gain-compensated
// CORDIC with one micro-rotation per register stage. x and y are rounded to Q16 and saturate.
// One vector is accepted every clock unless a stalled output has filled every stage. There are
// CORDIC_STAGES + 9 register stages (five for angle reduction and conversion, one per
// micro-rotation, four for gain, rounding and saturation). Each stage has its own valid bit
// and a stalled output only holds back stages that are full, so bubbles close up.
// There is no state beyond the pipeline and no configuration.

module rotate_vector_about_z_core
  import rvz_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input transactions
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // x_in[31:0], y_in[63:32], z_in[95:64], angle_deg[127:96]
  // result transactions
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata   // x_out[31:0], y_out[63:32], z_out[95:64]
);

  localparam int NF = 5;                      // angle front-end stages
  localparam int NB = 4;                      // gain and output stages
  localparam int NS = NF + CORDIC_STAGES + NB;
  localparam int HW = XW - 32;                // high part of the gain split
  localparam int QW = XW + 1 - GUARD;         // width after dropping the guard bits

  localparam logic [63:0] D2R = deg_to_rad();
  localparam logic [30:0] DH  = 31'(D2R >> 24);
  localparam logic [23:0] DL  = D2R[23:0];
  localparam logic [31:0] KG  = kgain_q32(CORDIC_STAGES);

  localparam logic [24:0]        C360 = 25'(DEG_Q16_360);
  localparam logic [24:0]        C180 = 25'(DEG_Q16_180);
  localparam logic signed [25:0] S360 = 26'(DEG_Q16_360);
  localparam logic signed [25:0] S180 = 26'(DEG_Q16_180);
  localparam logic signed [25:0] S90  = 26'(DEG_Q16_90);
  localparam logic [22:0]        M90  = 23'(DEG_Q16_90);

  // valid bits of every stage and the backward ready chain
  logic [NF-1:0]            vf_r;
  logic [CORDIC_STAGES-1:0] vc;
  logic [NB-1:0]            vb_r;
  logic [NS-1:0]            vld;
  logic [NS:0]              rdy;

  assign vld     = {vb_r, vc, vf_r};
  assign rdy[NS] = out_tready;

  // a stage loads when it is empty or its successor moves on
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~vld[k] | rdy[k+1];
  end

  assign in_tready = rdy[0];

  // ---------------- stage 1: angle magnitude, coarse quotient by 360 degrees
  // 360 degrees in Q16 is 45 * 2^19, so the low 19 bits pass and the rest is taken mod 45
  logic signed [31:0] ang;
  logic               f1_neg_nxt;
  logic [31:0]        f1_mag;
  logic [24:0]        f1_prod;

  logic        f1_neg_r;
  logic [12:0] f1_hi_r;
  logic [18:0] f1_lo_r;
  logic [6:0]  f1_q_r;
  logic [31:0] f1_x_r, f1_y_r, f1_z_r;

  always_comb begin
    ang        = signed'(in_tdata[127:96]);
    f1_neg_nxt = ang[31];
    f1_mag     = f1_neg_nxt ? (32'd0 - in_tdata[127:96]) : in_tdata[127:96];
    // reciprocal of 45 rounded down, low by at most one
    f1_prod    = 25'(f1_mag[31:19]) * 25'd2912;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      f1_neg_r <= f1_neg_nxt;
      f1_hi_r  <= f1_mag[31:19];
      f1_lo_r  <= f1_mag[18:0];
      f1_q_r   <= f1_prod[23:17];
      f1_x_r   <= in_tdata[31:0];
      f1_y_r   <= in_tdata[63:32];
      f1_z_r   <= in_tdata[95:64];
    end
  end

  // ---------------- stage 2: exact remainder, moved into [0, 360)
  logic [12:0] f2_r0;
  logic [5:0]  f2_r1;
  logic [24:0] f2_rem;
  logic [24:0] f2_a_nxt;

  logic [24:0] f2_a_r;
  logic [31:0] f2_x_r, f2_y_r, f2_z_r;

  always_comb begin
    f2_r0    = f1_hi_r - (13'(f1_q_r) * 13'd45);
    f2_r1    = (f2_r0 >= 13'd45) ? 6'(f2_r0 - 13'd45) : 6'(f2_r0);
    f2_rem   = {f2_r1, f1_lo_r};
    f2_a_nxt = (f1_neg_r && (f2_rem != '0)) ? (C360 - f2_rem) : f2_rem;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      f2_a_r <= f2_a_nxt;
      f2_x_r <= f1_x_r;
      f2_y_r <= f1_y_r;
      f2_z_r <= f1_z_r;
    end
  end

  // ---------------- stage 3: fold into [-90, 90], negating x and y when folded
  logic signed [25:0]   f3_a1;
  logic signed [25:0]   f3_a2;
  logic                 f3_flip;
  logic signed [XW-1:0] f3_xv;
  logic signed [XW-1:0] f3_yv;

  logic                 f3_sgn_r;
  logic [22:0]          f3_mag_r;
  logic signed [XW-1:0] f3_x_r, f3_y_r;
  logic [31:0]          f3_z_r;

  always_comb begin
    f3_a1 = (f2_a_r >= C180) ? (signed'({1'b0, f2_a_r}) - S360) : signed'({1'b0, f2_a_r});
    f3_a2   = f3_a1;
    f3_flip = 1'b0;
    if (f3_a1 > S90) begin
      f3_a2   = f3_a1 - S180;
      f3_flip = 1'b1;
    end else if (f3_a1 < -S90) begin
      f3_a2   = f3_a1 + S180;
      f3_flip = 1'b1;
    end
    f3_xv = signed'({{(XW-32-GUARD){f2_x_r[31]}}, f2_x_r, {GUARD{1'b0}}});
    f3_yv = signed'({{(XW-32-GUARD){f2_y_r[31]}}, f2_y_r, {GUARD{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      f3_sgn_r <= f3_a2[25];
      f3_mag_r <= f3_a2[25] ? 23'(-f3_a2) : 23'(f3_a2);
      f3_x_r   <= f3_flip ? -f3_xv : f3_xv;
      f3_y_r   <= f3_flip ? -f3_yv : f3_yv;
      f3_z_r   <= f2_z_r;
    end
  end

  // ---------------- stage 4: degrees to radians, split product
  logic                 f4_sgn_r;
  logic [53:0]          f4_ph_r;
  logic [46:0]          f4_pl_r;
  logic signed [XW-1:0] f4_x_r, f4_y_r;
  logic [31:0]          f4_z_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      f4_sgn_r <= f3_sgn_r;
      f4_ph_r  <= 54'(f3_mag_r) * 54'(DH);
      f4_pl_r  <= 47'(f3_mag_r) * 47'(DL);
      f4_x_r   <= f3_x_r;
      f4_y_r   <= f3_y_r;
      f4_z_r   <= f3_z_r;
    end
  end

  // ---------------- stage 5: combine into Q60 radians, low part rounded half up
  logic [61:0]          f5_rad;
  logic signed [ZW-1:0] f5_zr;
  rvz_cdc_t             f5_nxt;
  rvz_cdc_t             f5_r;

  always_comb begin
    f5_rad   = {f4_ph_r, 8'd0} + 62'((48'(f4_pl_r) + 48'h8000) >> 16);
    f5_zr    = signed'({1'b0, f5_rad});
    f5_nxt.x = f4_x_r;
    f5_nxt.y = f4_y_r;
    f5_nxt.z = f4_sgn_r ? -f5_zr : f5_zr;
    f5_nxt.zp = f4_z_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      f5_r <= f5_nxt;
    end
  end

  // front-end valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= '0;
    end else begin
      if (rdy[0]) begin
        vf_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NF; k++) begin
        if (rdy[k]) begin
          vf_r[k] <= vf_r[k-1];
        end
      end
    end
  end

  // ---------------- cordic micro-rotations, one per stage
  rvz_cdc_t cd [0:CORDIC_STAGES];

  assign cd[0] = f5_r;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    rvz_cordic_stage #(
      .STAGE_IDX(k)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .load  (rdy[NF+k]),
      .vld_i (vld[NF+k-1]),
      .d_i   (cd[k]),
      .vld_o (vc[k]),
      .d_o   (cd[k+1])
    );
  end

  // ---------------- stage G1: magnitudes for the gain product
  rvz_cdc_t   cq;
  logic       g1_nx_r, g1_ny_r;
  logic [XW-1:0] g1_ux_r, g1_uy_r;
  logic [31:0]   g1_z_r;

  assign cq = cd[CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (rdy[NS-4]) begin
      g1_nx_r <= cq.x[XW-1];
      g1_ny_r <= cq.y[XW-1];
      g1_ux_r <= cq.x[XW-1] ? unsigned'(-cq.x) : unsigned'(cq.x);
      g1_uy_r <= cq.y[XW-1] ? unsigned'(-cq.y) : unsigned'(cq.y);
      g1_z_r  <= cq.zp;
    end
  end

  // ---------------- stage G2: split gain multiply
  logic          g2_nx_r, g2_ny_r;
  logic [HW+31:0] g2_phx_r, g2_phy_r;
  logic [63:0]   g2_plx_r, g2_ply_r;
  logic [31:0]   g2_z_r;

  always_ff @(posedge clk) begin
    if (rdy[NS-3]) begin
      g2_nx_r  <= g1_nx_r;
      g2_ny_r  <= g1_ny_r;
      g2_phx_r <= (HW+32)'(g1_ux_r[XW-1:32]) * (HW+32)'(KG);
      g2_phy_r <= (HW+32)'(g1_uy_r[XW-1:32]) * (HW+32)'(KG);
      g2_plx_r <= 64'(g1_ux_r[31:0]) * 64'(KG);
      g2_ply_r <= 64'(g1_uy_r[31:0]) * 64'(KG);
      g2_z_r   <= g1_z_r;
    end
  end

  // ---------------- stage G3: sum of partial products, rounded half away from zero
  logic [XW-1:0]        g3_rx, g3_ry;
  logic signed [XW-1:0] g3_x_r, g3_y_r;
  logic [31:0]          g3_z_r;

  always_comb begin
    g3_rx = XW'(g2_phx_r) + XW'((65'(g2_plx_r) + 65'h80000000) >> 32);
    g3_ry = XW'(g2_phy_r) + XW'((65'(g2_ply_r) + 65'h80000000) >> 32);
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-2]) begin
      g3_x_r <= g2_nx_r ? -signed'(g3_rx) : signed'(g3_rx);
      g3_y_r <= g2_ny_r ? -signed'(g3_ry) : signed'(g3_ry);
      g3_z_r <= g2_z_r;
    end
  end

  // ---------------- stage G4: drop guard bits rounding half up, saturate to 32 bits
  logic signed [XW:0]   g4_tx, g4_ty;
  logic [QW-1:0]        g4_qx, g4_qy;
  logic [31:0]          g4_x_nxt, g4_y_nxt;
  logic [31:0]          g4_x_r, g4_y_r, g4_z_r;

  always_comb begin
    g4_tx = (XW+1)'(g3_x_r) + (XW+1)'(64'd1 << (GUARD - 1));
    g4_ty = (XW+1)'(g3_y_r) + (XW+1)'(64'd1 << (GUARD - 1));
    g4_qx = g4_tx[XW:GUARD];
    g4_qy = g4_ty[XW:GUARD];
    // in range when every bit from 31 up matches the sign
    if ((&g4_qx[QW-1:31]) || !(|g4_qx[QW-1:31])) begin
      g4_x_nxt = g4_qx[31:0];
    end else begin
      g4_x_nxt = g4_qx[QW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    if ((&g4_qy[QW-1:31]) || !(|g4_qy[QW-1:31])) begin
      g4_y_nxt = g4_qy[31:0];
    end else begin
      g4_y_nxt = g4_qy[QW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      g4_x_r <= g4_x_nxt;
      g4_y_r <= g4_y_nxt;
      g4_z_r <= g3_z_r;
    end
  end

  // back-end valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
    end else begin
      if (rdy[NS-NB]) begin
        vb_r[0] <= vc[CORDIC_STAGES-1];
      end
      for (int k = 1; k < NB; k++) begin
        if (rdy[NS-NB+k]) begin
          vb_r[k] <= vb_r[k-1];
        end
      end
    end
  end

  assign out_tvalid = vb_r[NB-1];
  assign out_tdata  = {g4_z_r, g4_y_r, g4_x_r};

  // ---------------- checks
  // a pipeline with any empty stage must take input
  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !(&vld) |-> in_tready)
    else $error("input stalled although a stage is empty");

  // an accepted transaction lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vf_r[0])
    else $error("accepted transaction lost at the first stage");

  // a held first stage keeps its item
  a_first_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vf_r[0] && !rdy[0]) |=> (vf_r[0] && $stable(f1_q_r) && $stable(f1_lo_r)))
    else $error("stalled first stage changed");

  // folded angle magnitude never exceeds 90 degrees
  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    vf_r[2] |-> (f3_mag_r <= M90))
    else $error("folded angle out of range");

endmodule

`default_nettype wire

FILE: src/rvz_cordic_stage.sv
`default_nettype none

module rvz_cordic_stage
  import rvz_pkg::*;
#(
  parameter int STAGE_IDX = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     load,
  input  wire logic     vld_i,
  input  wire rvz_cdc_t d_i,
  output logic          vld_o,
  output rvz_cdc_t      d_o
);

  localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q60(STAGE_IDX));

  logic                 vld_r;
  rvz_cdc_t             d_r;
  rvz_cdc_t             d_nxt;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  // one micro-rotation, direction from the sign of the residual angle
  always_comb begin
    dx    = d_i.y >>> STAGE_IDX;
    dy    = d_i.x >>> STAGE_IDX;
    d_nxt = d_i;
    if (!d_i.z[ZW-1]) begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - ATAN;
    end else begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

`default_nettype wire

FILE: verif/rotate_vector_about_z_core_test.sv
`timescale 1ns / 100ps

module rotate_vector_about_z_core_test;
  import rvz_pkg::*;

  // block configuration and timing
  localparam int STAGES      = CORDIC_STAGES_DEF;
  localparam int LATENCY     = STAGES + 9;
  localparam int TAIL_CYCLES = 2 * LATENCY;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4 * (HOLD_CYCLES + LATENCY + 16);
  localparam int PHASE_ITEMS = 488;
  localparam int REPORT_MAX  = 10;

  // q16 helpers for the directed vectors
  localparam int ONE = 65536;
  localparam int DEG = 65536;
  localparam logic signed [31:0] MAX_Q = 32'sh7fffffff;
  localparam logic signed [31:0] MIN_Q = 32'sh80000000;

  localparam longint TURN = DEG_Q16_360;
  localparam longint HALF = DEG_Q16_180;
  localparam longint QUAD = DEG_Q16_90;

  // one input transaction, x in the lowest bits of in_tdata
  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vec_item_t;

  // one result transaction, x in the lowest bits of out_tdata
  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } rot_result_t;

  // rotation predictor and store of expected rotated vectors
  class rotation_scoreboard;
    longint            atan_q60[STAGES];
    longint unsigned   rad_per_deg;
    longint unsigned   inv_gain;
    rot_result_t       expected_rot[$];
    int                failures;
    int                checked;
    int                folded;
    int                saturated;

    function new();
      longint          qpi;
      longint unsigned g;
      longint unsigned root;
      failures  = 0;
      checked   = 0;
      folded    = 0;
      saturated = 0;
      // machin formula for pi/4, all angles in q60 radians
      qpi = 4 * atan_series(5) - atan_series(239);
      rad_per_deg = (unsigned'(qpi) * 4 + 90) / 180;
      atan_q60[0] = qpi;
      for (int i = 1; i < STAGES; i++) begin
        atan_q60[i] = atan_series(64'd1 << i);
      end
      // inverse of the accumulated cordic gain, q32
      g = 64'd1 << 60;
      for (int i = 0; i < STAGES; i++) begin
        g += g >> (2 * i);
      end
      root = int_sqrt(g);
      inv_gain = ((64'd1 << 62) + root / 2) / root;
    endfunction

    // atan(1/m) in q60 from its power series
    function longint atan_series(longint unsigned m);
      longint unsigned term;
      longint unsigned m2;
      longint unsigned k;
      longint          sum;
      longint          t;
      term = (64'd1 << 60) / m;
      m2   = m * m;
      sum  = 0;
      k    = 0;
      while (term != 0) begin
        t = longint'(term / (2 * k + 1));
        sum = k[0] ? sum - t : sum + t;
        term = term / m2;
        k++;
      end
      return sum;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned bit_w;
      rem   = v;
      root  = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > rem) begin
        bit_w >>= 2;
      end
      while (bit_w != 0) begin
        if (rem >= root + bit_w) begin
          rem -= root + bit_w;
          root = (root >> 1) + bit_w;
        end else begin
          root >>= 1;
        end
        bit_w >>= 2;
      end
      return root;
    endfunction

    // gain compensation, rounding to q16 and saturation of one component
    function logic signed [31:0] to_q16(input longint v, output bit clipped);
      bit              neg;
      longint unsigned u;
      longint unsigned r;
      longint          scaled;
      longint          q;
      neg = v < 0;
      u = neg ? unsigned'(-v) : unsigned'(v);
      r = (u >> 32) * inv_gain
          + (((u & 64'hFFFFFFFF) * inv_gain + (64'd1 << 31)) >> 32);
      scaled = neg ? -longint'(r) : longint'(r);
      q = (scaled + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
      clipped = 1'b0;
      if (q > 64'sd2147483647) begin
        q = 64'sd2147483647;
        clipped = 1'b1;
      end else if (q < -64'sd2147483648) begin
        q = -64'sd2147483648;
        clipped = 1'b1;
      end
      return q[31:0];
    endfunction

    function rot_result_t rotate_about_z(vec_item_t it);
      longint          xv;
      longint          yv;
      longint          a;
      longint          z;
      longint          dx;
      longint          dy;
      longint unsigned mag;
      longint unsigned rad;
      bit              cx;
      bit              cy;
      rot_result_t     r;
      xv = longint'(it.x) <<< GUARD;
      yv = longint'(it.y) <<< GUARD;
      // exact reduction in q16 degrees to [-180, 180)
      a = longint'(it.angle) % TURN;
      if (a < 0) a += TURN;
      if (a >= HALF) a -= TURN;
      // fold into [-90, 90] by turning the vector half a turn
      if (a > QUAD) begin
        a -= HALF;
        xv = -xv;
        yv = -yv;
        folded++;
      end else if (a < -QUAD) begin
        a += HALF;
        xv = -xv;
        yv = -yv;
        folded++;
      end
      // degrees to q60 radians with a split product
      mag = unsigned'(a < 0 ? -a : a);
      rad = ((mag * (rad_per_deg >> 24)) << 8)
            + ((mag * (rad_per_deg & 64'hFFFFFF) + 64'h8000) >> 16);
      z = a < 0 ? -longint'(rad) : longint'(rad);
      for (int i = 0; i < STAGES; i++) begin
        dx = yv >>> i;
        dy = xv >>> i;
        if (z >= 0) begin
          xv -= dx;
          yv += dy;
          z  -= atan_q60[i];
        end else begin
          xv += dx;
          yv -= dy;
          z  += atan_q60[i];
        end
      end
      r.x = to_q16(xv, cx);
      r.y = to_q16(yv, cy);
      r.z = it.z;
      if (cx || cy) saturated++;
      return r;
    endfunction

    function void note_vector(vec_item_t it);
      expected_rot.push_back(rotate_about_z(it));
    endfunction

    function void check_result(rot_result_t got);
      rot_result_t want;
      if (expected_rot.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX) begin
          $display("unexpected result x %h y %h z %h", got.x, got.y, got.z);
        end
        return;
      end
      want = expected_rot.pop_front();
      checked++;
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
        failures++;
        if (failures <= REPORT_MAX) begin
          $display("result %0d: x exp %h got %h, y exp %h got %h, z exp %h got %h",
                   checked, want.x, got.x, want.y, got.y, want.z, got.z);
        end
      end
    endfunction

    function int outstanding();
      return expected_rot.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;    // x_in, y_in, z_in, angle_deg
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;   // x_out, y_out, z_out

  rotation_scoreboard sb;

  // idling control shared by the stimulus and the receiver
  bit in_idle_en;
  bit out_idle_en;
  bit hold_results;
  int holds_done;
  int quiet_cycles = 0;

  rotate_vector_about_z_core #(
    .CORDIC_STAGES(STAGES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_cycles(bit en);
    return en ? int'($urandom_range(0, 8)) : 0;
  endfunction

  function automatic vec_item_t vec(logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z, logic signed [31:0] ang);
    vec_item_t v;
    v.x     = x;
    v.y     = y;
    v.z     = z;
    v.angle = ang;
    return v;
  endfunction

  // vector component: full range, scaled down, small, or a corner value
  function automatic logic signed [31:0] rand_component();
    logic signed [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom();
      2: v = $signed($urandom()) >>> $urandom_range(8, 30);
      3: v = $signed($urandom()) >>> 14;
      4: begin
        case ($urandom_range(0, 3))
          0: v = MIN_Q;
          1: v = MAX_Q;
          2: v = 0;
          default: v = -1;
        endcase
      end
      default: v = $signed($urandom()) >>> 1;
    endcase
    return v;
  endfunction

  // angle: full range, one turn either way, near a quadrant edge, tiny, many turns
  function automatic logic signed [31:0] rand_angle();
    logic signed [31:0] a;
    case ($urandom_range(0, 4))
      0: a = $urandom();
      1: a = int'($urandom_range(0, 2 * DEG_Q16_360)) - DEG_Q16_360;
      2: a = (int'($urandom_range(0, 16)) - 8) * DEG_Q16_90 + int'($urandom_range(0, 8)) - 4;
      3: a = int'($urandom_range(0, 2 * ONE)) - ONE;
      default: a = (int'($urandom_range(0, 90)) - 45) * DEG_Q16_360
                   + int'($urandom_range(0, DEG_Q16_360 - 1));
    endcase
    return a;
  endfunction

  // offer one vector after a random gap and hold it until accepted;
  // returns at a falling edge with in_tvalid still high
  task automatic send_vector(vec_item_t v);
    int gap;
    gap = idle_cycles(in_idle_en);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // sample both channels at the rising edge, where transactions complete
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_vector(vec_item_t'(in_tdata));
      if (out_tvalid && out_tready) sb.check_result(rot_result_t'(out_tdata));
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, sb.outstanding());
        $display("rotate_vector_about_z_core verification failed");
        $finish;
      end
    end
  end

  // result receiver: random stalls per result, and a long hold-off on request
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_results) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
        holds_done++;
      end else begin
        stall = idle_cycles(out_idle_en);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_idle_en   = 1'b1;
    out_idle_en  = 1'b1;
    hold_results = 1'b0;
    holds_done   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero, quadrant edges on both sides of the fold, whole turns,
    // full-scale components that saturate, negation of the most negative value,
    // extreme angles that need the modulo, and z bit patterns passed through
    send_vector(vec(0, 0, 0, 0));
    send_vector(vec(ONE, 0, 0, 0));
    send_vector(vec(ONE, 0, 0, 90 * DEG));
    send_vector(vec(ONE, 0, 0, 90 * DEG + 1));
    send_vector(vec(ONE, 0, 0, -90 * DEG));
    send_vector(vec(ONE, 0, 0, -90 * DEG - 1));
    send_vector(vec(ONE, ONE, 0, 180 * DEG));
    send_vector(vec(ONE, ONE, 0, -180 * DEG));
    send_vector(vec(ONE, 2 * ONE, 0, 360 * DEG));
    send_vector(vec(3 * ONE, -ONE, 0, 45 * DEG));
    send_vector(vec(ONE, 0, 0, 30 * DEG));
    send_vector(vec(ONE, 0, 0, 270 * DEG));
    send_vector(vec(MAX_Q, MAX_Q, MAX_Q, 45 * DEG));
    send_vector(vec(MIN_Q, MIN_Q, MIN_Q, 45 * DEG));
    send_vector(vec(MIN_Q, 0, -1, 180 * DEG));
    send_vector(vec(MIN_Q, MIN_Q, 0, 0));
    send_vector(vec(MAX_Q, MIN_Q, 0, 90 * DEG));
    send_vector(vec(ONE, ONE, 0, MAX_Q));
    send_vector(vec(ONE, ONE, 0, MIN_Q));
    send_vector(vec(-1, 1, 32'sh55555555, 1));
    send_vector(vec(ONE, -ONE, 32'shAAAAAAAA, -1));
    send_vector(vec(12345678, -87654321, 0, 360 * DEG - 1));
    send_vector(vec(ONE, 0, 0, -360 * DEG));
    send_vector(vec(MAX_Q, 0, 0, 60 * DEG));

    // random phases with different idling on each side
    for (int phase = 0; phase < 4; phase++) begin
      in_idle_en  = (phase == 0) || (phase == 3);
      out_idle_en = (phase == 0) || (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // back-to-back input while the output is held: pipeline fills, input stalls
        if (phase == 1 && n == 40) hold_results = 1'b1;
        // sender goes quiet until every result is back
        if (phase == 2 && n == 100) begin
          in_tvalid <= 1'b0;
          @(negedge clk);
          while (sb.outstanding() != 0) @(negedge clk);
        end
        send_vector(vec(rand_component(), rand_component(), rand_component(), rand_angle()));
      end
    end
    in_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d vectors rotated and checked: %0d folded past a right angle, %0d saturated",
             sb.checked, sb.folded, sb.saturated);
    $display("random idling on both sides, %0d long output hold-off(s), one full drain",
             holds_done);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("rotate_vector_about_z_core verification clean");
    end else begin
      $display("%0d failure(s), %0d results never arrived", sb.failures, sb.outstanding());
      $display("rotate_vector_about_z_core verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/rvz_pkg.sv
src/rvz_cordic_stage.sv
src/rotate_vector_about_z_core.sv
verif/rotate_vector_about_z_core_test.sv
